// ----- rtl/core/http_request_header_detector_assert.svh -----
// Assertion macros for the HTTP request header detector.
// Included by files that check their own logic; no other dependencies.
`ifndef HTTP_REQUEST_HEADER_DETECTOR_ASSERT_SVH
`define HTTP_REQUEST_HEADER_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HRHD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("HRHD implication check failed");
`define HRHD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("HRHD next-cycle check failed");
`else
`define HRHD_ASSERT_IMPL(lbl, ante, cons)
`define HRHD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/hrhd_pkg.sv -----
// Shared types, codes and the method classifier for the header detector.
// No dependencies.
package hrhd_pkg;

	localparam int unsigned CountWidth = 16;
	localparam int unsigned MaxSizeWidth = 16;
	localparam logic [MaxSizeWidth-1:0] MaxSizeReset = 16'd8192;
	localparam logic [CountWidth-1:0] CountMax = '1;

	localparam logic [7:0] ChCr = 8'h0D;
	localparam logic [7:0] ChLf = 8'h0A;

	localparam logic [31:0] WordGet = 32'h4745_5420;
	localparam logic [31:0] WordHead = 32'h4845_4144;
	localparam logic [31:0] WordPost = 32'h504F_5354;
	localparam logic [31:0] WordPut = 32'h5055_5420;

	typedef enum logic [2:0] {
		M_UNSET = 3'd0,
		M_GET = 3'd1,
		M_HEAD = 3'd2,
		M_PUT = 3'd3,
		M_POST = 3'd4,
		M_INVALID = 3'd5
	} method_t;

	typedef enum logic [1:0] {
		ST_CONTINUE = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_INVALID = 2'd2,
		ST_OVERSIZE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TS_IDLE = 2'd0,
		TS_CR = 2'd1,
		TS_CRLF = 2'd2,
		TS_LF = 2'd3
	} term_state_t;

	typedef struct packed {
		logic step;
		logic clear;
	} step_ctl_t;

	function automatic method_t classify(input logic [31:0] word);
		method_t m;
		if (word == WordGet) m = M_GET;
		else if (word == WordHead) m = M_HEAD;
		else if (word == WordPost) m = M_POST;
		else if (word == WordPut) m = M_PUT;
		else m = M_INVALID;
		return m;
	endfunction

endpackage

// ----- rtl/core/http_request_header_detector.sv -----
// HTTP request header detector: one byte in, one status out per transfer.
// Bytes pass an input register, then a result register; the state updates as a byte
// moves between them. One byte per cycle unless out_ready stalls the result register.
// Reset clears the pipeline, byte counter, method and search state; max_size returns to 8192.
// Depends on hrhd_pkg, hrhd_method, hrhd_term and http_request_header_detector_assert.svh.
module http_request_header_detector import hrhd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic new_connection,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [2:0] method,
	output logic [15:0] byte_total,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	`include "http_request_header_detector_assert.svh"

	logic [MaxSizeWidth-1:0] max_size_q;
	logic valid_s1;
	logic [7:0] data_s1;
	logic newc_s1;
	logic valid_s2;
	status_t status_s2;
	method_t method_s2;
	logic [CountWidth-1:0] count_s2;
	logic [CountWidth-1:0] count_q;
	logic [CountWidth-1:0] count_cur;
	logic [CountWidth-1:0] count_next;
	logic s2_ready;
	step_ctl_t ctl;
	method_t method_next;
	logic invalid_now;
	logic search_en;
	logic complete;
	status_t status_next;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-MaxSizeWidth){1'b0}}, max_size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= MaxSizeReset;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			max_size_q <= pwdata[MaxSizeWidth-1:0];
		end
	end

	// Handshake
	assign s2_ready = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s2_ready;
	assign ctl.step = valid_s1 && s2_ready;
	assign ctl.clear = newc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_s1 <= data_byte;
			newc_s1 <= new_connection;
		end
	end

	// Byte counter
	assign count_cur = newc_s1 ? '0 : count_q;
	assign count_next = (count_cur == CountMax) ? count_cur : count_cur + CountWidth'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.step) begin
			count_q <= count_next;
		end
	end

	hrhd_method u_method (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.ch(data_s1),
		.count_cur(count_cur),
		.method_next(method_next),
		.invalid_now(invalid_now)
	);

	always_comb begin
		search_en = 1'b0;
		if (method_next inside {[M_GET:M_POST]}) search_en = 1'b1;
	end

	hrhd_term u_term (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.search_en(search_en),
		.ch(data_s1),
		.complete(complete)
	);

	always_comb begin
		if (complete) status_next = ST_COMPLETE;
		else if (invalid_now) status_next = ST_INVALID;
		else if (count_next > max_size_q) status_next = ST_OVERSIZE;
		else status_next = ST_CONTINUE;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			status_s2 <= status_next;
			method_s2 <= method_next;
			count_s2 <= count_next;
		end
	end

	assign out_valid = valid_s2;
	assign status = status_s2;
	assign method = method_s2;
	assign byte_total = count_s2;

	`HRHD_ASSERT_IMPL(a_complete_needs_method, valid_s2 && (status_s2 == ST_COMPLETE), (method_s2 == M_GET) || (method_s2 == M_HEAD) || (method_s2 == M_PUT) || (method_s2 == M_POST))
	`HRHD_ASSERT_IMPL(a_invalid_at_fourth, valid_s2 && (status_s2 == ST_INVALID), (method_s2 == M_INVALID) && (count_s2 == CountWidth'(4)))
	`HRHD_ASSERT_IMPL(a_oversize_count, valid_s2 && (status_s2 == ST_OVERSIZE), count_s2 > max_size_q)
	`HRHD_ASSERT_NEXT(a_step_fills_result, ctl.step, valid_s2)

endmodule

// ----- rtl/core/hrhd_method.sv -----
// Collects the first three bytes and classifies the request method at the fourth.
// Depends on hrhd_pkg.
module hrhd_method import hrhd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input step_ctl_t ctl,
	input logic [7:0] ch,
	input logic [CountWidth-1:0] count_cur,
	output method_t method_next,
	output logic invalid_now
);

	method_t method_q;
	method_t method_cur;
	logic [7:0] first_q [3];
	logic collect;
	logic classify_now;

	assign method_cur = ctl.clear ? M_UNSET : method_q;
	assign collect = (method_cur == M_UNSET) && (count_cur < CountWidth'(3));
	assign classify_now = (method_cur == M_UNSET) && (count_cur == CountWidth'(3));

	always_comb begin
		method_next = method_cur;
		if (classify_now) begin
			method_next = classify({first_q[0], first_q[1], first_q[2], ch});
		end
	end

	assign invalid_now = classify_now && (method_next == M_INVALID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= M_UNSET;
		end else if (ctl.step) begin
			method_q <= method_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && collect) begin
			first_q[count_cur[1:0]] <= ch;
		end
	end

endmodule

// ----- rtl/core/hrhd_term.sv -----
// Blank-line search state machine (CR LF CR LF, CR LF LF or LF LF) over the byte stream.
// Depends on hrhd_pkg.
module hrhd_term import hrhd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input step_ctl_t ctl,
	input logic search_en,
	input logic [7:0] ch,
	output logic complete
);

	term_state_t state_q;
	term_state_t state_cur;
	term_state_t state_next;

	assign state_cur = ctl.clear ? TS_IDLE : state_q;

	always_comb begin
		state_next = state_cur;
		if (search_en) begin
			case (state_cur)
				TS_IDLE: begin
					if (ch == ChCr) state_next = TS_CR;
					else if (ch == ChLf) state_next = TS_LF;
				end
				TS_CR: begin
					state_next = (ch == ChLf) ? TS_CRLF : TS_IDLE;
				end
				TS_CRLF: begin
					if (ch != ChLf) state_next = (ch == ChCr) ? TS_LF : TS_IDLE;
				end
				TS_LF: begin
					if (ch != ChLf) state_next = (ch == ChCr) ? TS_CR : TS_IDLE;
				end
				default: begin
					state_next = TS_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		complete = 1'b0;
		case (state_cur)
			TS_CRLF, TS_LF: begin
				complete = search_en && (ch == ChLf);
			end
			default: begin
				complete = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
		end else if (ctl.step) begin
			state_q <= state_next;
		end
	end

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for http_request_header_detector: a directed byte table, then
// random connections, with both sides idling and the size limit set over the APB-style port.
// Depends on hrhd_pkg and the detector RTL.
module tb;
	import hrhd_pkg::*;

	localparam logic [2:0] RegMaxSize = 3'd0;
	localparam int CycleLimit = 400000;
	localparam int NumProbes = 27;
	localparam int PhaseItems = 100;

	typedef struct {
		status_t status;
		method_t method;
		logic [15:0] total;
	} verdict_t;

	typedef struct {
		logic [7:0] ch;
		logic nc;
		bit typed;
		status_t status;
		method_t method;
		logic [15:0] total;
	} probe_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic new_connection = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [2:0] method;
	logic [15:0] byte_total;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	// Predicted detector state.
	logic [15:0] size_limit = 16'd8192;
	logic [15:0] seen_count = 16'd0;
	method_t seen_method = M_UNSET;
	term_state_t blank_line_state = TS_IDLE;
	logic [7:0] lead_bytes [3];

	verdict_t pending_verdicts [$];
	verdict_t arrived_want;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;
	int cycle_count = 0;
	int error_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int completes_seen = 0;
	int invalids_seen = 0;
	int oversizes_seen = 0;
	int limits_written = 0;

	probe_t probes [NumProbes] = '{
		'{"G", 1'b1, 1'b1, ST_CONTINUE, M_UNSET, 16'd1},
		'{"E", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"T", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{" ", 1'b0, 1'b1, ST_CONTINUE, M_GET, 16'd4},
		'{ChCr, 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{ChLf, 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{ChCr, 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{ChLf, 1'b0, 1'b1, ST_COMPLETE, M_GET, 16'd8},
		'{ChLf, 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"H", 1'b1, 1'b1, ST_CONTINUE, M_UNSET, 16'd1},
		'{"E", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"A", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"D", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{ChLf, 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{ChLf, 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"P", 1'b1, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"U", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"T", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{" ", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"P", 1'b1, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"O", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"S", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{"T", 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{8'hFF, 1'b1, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{8'hFF, 1'b0, 1'b0, ST_CONTINUE, M_UNSET, 16'd0},
		'{8'h00, 1'b0, 1'b1, ST_INVALID, M_INVALID, 16'd4}
	};

	http_request_header_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.new_connection(new_connection),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.method(method),
		.byte_total(byte_total),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Updates the predicted state with one accepted byte and queues the status it must yield.
	task automatic track_byte(input logic [7:0] ch, input logic nc);
		verdict_t v;
		logic found;
		found = 1'b0;
		v.status = ST_CONTINUE;
		if (nc) begin
			seen_count = 16'd0;
			seen_method = M_UNSET;
			blank_line_state = TS_IDLE;
		end
		if (seen_method == M_UNSET && seen_count < 16'd3)
			lead_bytes[seen_count[1:0]] = ch;
		if (seen_count != 16'hFFFF)
			seen_count = seen_count + 16'd1;
		if (seen_method == M_UNSET && seen_count == 16'd4) begin
			case ({lead_bytes[0], lead_bytes[1], lead_bytes[2], ch})
				"GET ": seen_method = M_GET;
				"HEAD": seen_method = M_HEAD;
				"POST": seen_method = M_POST;
				"PUT ": seen_method = M_PUT;
				default: seen_method = M_INVALID;
			endcase
			if (seen_method == M_INVALID) begin
				v.status = ST_INVALID;
				found = 1'b1;
			end
		end
		if (!found && seen_method != M_UNSET && seen_method != M_INVALID) begin
			case (blank_line_state)
				TS_IDLE: begin
					if (ch == ChCr)
						blank_line_state = TS_CR;
					else if (ch == ChLf)
						blank_line_state = TS_LF;
				end
				TS_CR: blank_line_state = (ch == ChLf) ? TS_CRLF : TS_IDLE;
				TS_CRLF: begin
					if (ch == ChLf) begin
						v.status = ST_COMPLETE;
						found = 1'b1;
					end else
						blank_line_state = (ch == ChCr) ? TS_LF : TS_IDLE;
				end
				default: begin
					if (ch == ChLf) begin
						v.status = ST_COMPLETE;
						found = 1'b1;
					end else
						blank_line_state = (ch == ChCr) ? TS_CR : TS_IDLE;
				end
			endcase
		end
		if (!found && seen_count > size_limit)
			v.status = ST_OVERSIZE;
		v.method = seen_method;
		v.total = seen_count;
		pending_verdicts.push_back(v);
	endtask

	task automatic send_byte(input logic [7:0] ch, input logic nc);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= ch;
		new_connection <= nc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_byte(ch, nc);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size_limit(input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RegMaxSize;
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_limit = val;
		limits_written++;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[15:0] !== val) begin
			$error("max_size readback expected %0d got %0d", val, prdata[15:0]);
			error_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// One connection: a method word (mostly valid, sometimes cut short), a header body and usually a blank line.
	task automatic send_connection();
		logic [31:0] word;
		logic [31:0] tail;
		int pick;
		int body_len;
		int sel;
		pick = $urandom_range(0, 9);
		case (pick % 4)
			0: word = "GET ";
			1: word = "HEAD";
			2: word = "PUT ";
			default: word = "POST";
		endcase
		if (pick == 8)
			word = $urandom;
		else if (pick == 9)
			word[8 * $urandom_range(0, 3) +: 8] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			for (int i = 3; i >= 4 - $urandom_range(1, 3); i--)
				send_byte(word[8 * i +: 8], i == 3);
			return;
		end
		for (int i = 3; i >= 0; i--)
			send_byte(word[8 * i +: 8], i == 3);
		body_len = $urandom_range(0, 24);
		for (int i = 0; i < body_len; i++) begin
			sel = $urandom_range(0, 4);
			send_byte(sel == 0 ? ChCr : sel == 1 ? ChLf : 8'($urandom_range(0, 255)),
				$urandom_range(0, 49) == 0);
		end
		sel = $urandom_range(0, 4);
		if (sel < 2) begin
			tail = {ChCr, ChLf, ChCr, ChLf};
			for (int i = 3; i >= 0; i--)
				send_byte(tail[8 * i +: 8], 1'b0);
		end else if (sel < 4) begin
			send_byte(ChLf, 1'b0);
			send_byte(ChLf, 1'b0);
		end
	endtask

	task automatic run_traffic(input int target);
		int start;
		bit paused;
		start = items_sent;
		paused = 1'b0;
		while (items_sent - start < target) begin
			send_connection();
			if (!paused && items_sent - start >= target / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected transfer: status %0d method %0d byte_total %0d",
						status, method, byte_total);
					error_count++;
				end else begin
					arrived_want = pending_verdicts.pop_front();
					if (status !== arrived_want.status) begin
						$error("status expected %0d got %0d", arrived_want.status, status);
						error_count++;
					end
					if (method !== arrived_want.method) begin
						$error("method expected %0d got %0d", arrived_want.method, method);
						error_count++;
					end
					if (byte_total !== arrived_want.total) begin
						$error("byte_total expected %0d got %0d", arrived_want.total,
							byte_total);
						error_count++;
					end
				end
				results_checked++;
				if (status == ST_COMPLETE)
					completes_seen++;
				else if (status == ST_INVALID)
					invalids_seen++;
				else if (status == ST_OVERSIZE)
					oversizes_seen++;
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NumProbes; i++) begin
			send_byte(probes[i].ch, probes[i].nc);
			if (probes[i].typed)
				pending_verdicts[pending_verdicts.size() - 1] =
					'{probes[i].status, probes[i].method, probes[i].total};
		end
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					write_size_limit(16'd1);
					hold_off_cycles = 300;
				end
				1: begin
					send_idle_pct = 80;
					recv_stall_pct = 0;
					write_size_limit(16'd65534);
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 80;
					write_size_limit(16'($urandom_range(2, 64)));
				end
				default: begin
					send_idle_pct = 7;
					recv_stall_pct = 7;
					write_size_limit(16'($urandom_range(1, 600)));
				end
			endcase
			run_traffic(PhaseItems);
			wait_drained();
		end

		repeat (8) @(posedge clk);

		$display("summary: %0d transfers checked over %0d size limits", results_checked,
			limits_written);
		$display("summary: %0d header complete, %0d invalid method, %0d over the limit",
			completes_seen, invalids_seen, oversizes_seen);
		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/hrhd_pkg.sv
rtl/core/hrhd_method.sv
rtl/core/hrhd_term.sv
rtl/core/http_request_header_detector.sv
test/tb.sv
